// ===== hw/rtl/slle_pkg.sv =====
package slle_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CAPACITY   = DEPTH - 2;

  localparam int KIND_W  = 2;
  localparam int POS_W   = 10;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 10;

  localparam logic [ADDR_W-1:0] FREE_SLOT = '0;
  localparam logic [ADDR_W-1:0] HEAD_SLOT = ADDR_W'(DEPTH - 1);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    RA_FREE = 2'd0,
    RA_RDQ  = 2'd1,
    RA_CUR  = 2'd2
  } raddr_sel_e;

  typedef enum logic [1:0] {
    WA_FREE  = 2'd0,
    WA_SLOT  = 2'd1,
    WA_PREV  = 2'd2,
    WA_SWEEP = 2'd3
  } waddr_sel_e;

  typedef enum logic [1:0] {
    WD_RDQ   = 2'd0,
    WD_SLOT  = 2'd1,
    WD_SWEEP = 2'd2
  } wdata_sel_e;

  typedef struct packed {
    logic       cap_in;
    raddr_sel_e rd_sel;
    logic       link_we;
    waddr_sel_e wa_sel;
    wdata_sel_e wd_sel;
    logic       data_we;
    logic       walk_init;
    logic       walk_step;
    logic       latch_prev;
    logic       latch_slot;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       set_err;
    logic       sweep_clr;
    logic       sweep_step;
    logic       load_out;
  } slle_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ins_ok;
    logic              del_ok;
    logic              slot_bad;
    logic              walk_done;
    logic              sweep_last;
    logic              out_free;
  } slle_status_t;

endpackage

// ===== hw/rtl/slle_if.sv =====
interface slle_req_if import slle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink (input valid, input kind, input position, input value, output ready);
endinterface

interface slle_rsp_if import slle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [LEN_W-1:0] length;

  modport source (output valid, output status, output length, input ready);
  modport sink (input valid, input status, input length, output ready);
endinterface

// ===== hw/rtl/slle_ctrl.sv =====
module slle_ctrl import slle_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  slle_status_t status_i,
  output slle_cmd_t    cmd_o
);

  typedef enum logic [13:0] {
    S_INIT  = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_CHECK = 14'b00000000000100,
    S_INS_A = 14'b00000000001000,
    S_INS_B = 14'b00000000010000,
    S_INS_C = 14'b00000000100000,
    S_INS_D = 14'b00000001000000,
    S_WALK  = 14'b00000010000000,
    S_DEL_A = 14'b00000100000000,
    S_DEL_B = 14'b00001000000000,
    S_DEL_C = 14'b00010000000000,
    S_DEL_D = 14'b00100000000000,
    S_CLEAR = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RA_CUR;
    cmd_o.wa_sel = WA_FREE;
    cmd_o.wd_sel = WD_RDQ;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        case (status_i.kind)
          KIND_INSERT: begin
            if (status_i.ins_ok) begin
              cmd_o.rd_sel = RA_FREE;
              state_d = S_INS_A;
            end else begin
              cmd_o.set_err = 1'b1;
              state_d = S_DONE;
            end
          end
          KIND_DELETE: begin
            if (status_i.del_ok) begin
              cmd_o.walk_init = 1'b1;
              state_d = S_WALK;
            end else begin
              cmd_o.set_err = 1'b1;
              state_d = S_DONE;
            end
          end
          KIND_CLEAR: begin
            cmd_o.sweep_clr = 1'b1;
            state_d = S_CLEAR;
          end
          default: begin
            cmd_o.set_err = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_INS_A: begin
        cmd_o.latch_slot = 1'b1;
        if (status_i.slot_bad) begin
          cmd_o.set_err = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_sel = RA_RDQ;
          state_d = S_INS_B;
        end
      end
      S_INS_B: begin
        cmd_o.link_we   = 1'b1;
        cmd_o.wa_sel    = WA_FREE;
        cmd_o.wd_sel    = WD_RDQ;
        cmd_o.data_we   = 1'b1;
        cmd_o.walk_init = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.rd_sel = RA_CUR;
        if (status_i.walk_done) begin
          cmd_o.latch_prev = 1'b1;
          state_d = (status_i.kind == KIND_INSERT) ? S_INS_C : S_DEL_A;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_INS_C: begin
        cmd_o.link_we = 1'b1;
        cmd_o.wa_sel  = WA_SLOT;
        cmd_o.wd_sel  = WD_RDQ;
        state_d = S_INS_D;
      end
      S_INS_D: begin
        cmd_o.link_we = 1'b1;
        cmd_o.wa_sel  = WA_PREV;
        cmd_o.wd_sel  = WD_SLOT;
        cmd_o.cnt_inc = 1'b1;
        state_d = S_DONE;
      end
      S_DEL_A: begin
        cmd_o.latch_slot = 1'b1;
        if (status_i.slot_bad) begin
          cmd_o.set_err = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_sel = RA_RDQ;
          state_d = S_DEL_B;
        end
      end
      S_DEL_B: begin
        cmd_o.link_we = 1'b1;
        cmd_o.wa_sel  = WA_PREV;
        cmd_o.wd_sel  = WD_RDQ;
        cmd_o.rd_sel  = RA_FREE;
        state_d = S_DEL_C;
      end
      S_DEL_C: begin
        cmd_o.link_we = 1'b1;
        cmd_o.wa_sel  = WA_SLOT;
        cmd_o.wd_sel  = WD_RDQ;
        state_d = S_DEL_D;
      end
      S_DEL_D: begin
        cmd_o.link_we = 1'b1;
        cmd_o.wa_sel  = WA_FREE;
        cmd_o.wd_sel  = WD_SLOT;
        cmd_o.cnt_dec = 1'b1;
        state_d = S_DONE;
      end
      S_INIT, S_CLEAR: begin
        cmd_o.link_we    = 1'b1;
        cmd_o.wa_sel     = WA_SWEEP;
        cmd_o.wd_sel     = WD_SWEEP;
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = (state_q == S_CLEAR) ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/slle_datapath.sv =====
module slle_datapath import slle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slle_cmd_t          cmd_i,
  output slle_status_t       status_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_status_o,
  output logic [LEN_W-1:0]   out_length_o
);

  logic [ADDR_W-1:0]     link_mem [DEPTH];
  logic [DATA_WIDTH-1:0] data_mem [DEPTH];

  logic [KIND_W-1:0]  kind_q;
  logic [POS_W-1:0]   pos_q;
  logic [VALUE_W-1:0] value_q;
  logic [LEN_W-1:0]   count_q;
  logic [ADDR_W-1:0]  rd_q;
  logic [ADDR_W-1:0]  slot_q;
  logic [ADDR_W-1:0]  prev_q;
  logic [POS_W-1:0]   remain_q;
  logic               first_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic               err_q;
  logic               out_valid_q;
  logic               out_status_q;
  logic [LEN_W-1:0]   out_length_q;

  logic [ADDR_W-1:0] cur;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] wdata;
  logic [ADDR_W-1:0] sweep_next;

  assign cur        = first_q ? HEAD_SLOT : rd_q;
  assign sweep_next = (sweep_q == HEAD_SLOT) ? FREE_SLOT : sweep_q + ADDR_W'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RA_FREE: raddr = FREE_SLOT;
      RA_RDQ:  raddr = rd_q;
      RA_CUR:  raddr = cur;
      default: raddr = cur;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wa_sel)
      WA_FREE:  waddr = FREE_SLOT;
      WA_SLOT:  waddr = slot_q;
      WA_PREV:  waddr = prev_q;
      WA_SWEEP: waddr = sweep_q;
      default:  waddr = FREE_SLOT;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wd_sel)
      WD_RDQ:   wdata = rd_q;
      WD_SLOT:  wdata = slot_q;
      WD_SWEEP: wdata = sweep_next;
      default:  wdata = rd_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_we) begin
      link_mem[waddr] <= wdata;
    end
    rd_q <= link_mem[raddr];
    if (cmd_i.data_we) begin
      data_mem[slot_q] <= DATA_WIDTH'(value_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      kind_q  <= kind_i;
      pos_q   <= position_i;
      value_q <= value_i;
    end
    if (cmd_i.latch_slot) begin
      slot_q <= rd_q;
    end
    if (cmd_i.latch_prev) begin
      prev_q <= cur;
    end
    if (cmd_i.walk_init) begin
      remain_q <= pos_q - POS_W'(1);
    end else if (cmd_i.walk_step) begin
      remain_q <= remain_q - POS_W'(1);
    end
    if (cmd_i.load_out) begin
      out_status_q <= err_q;
      out_length_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      first_q     <= 1'b1;
      sweep_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        count_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + LEN_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - LEN_W'(1);
      end
      if (cmd_i.walk_init) begin
        first_q <= 1'b1;
      end else if (cmd_i.walk_step) begin
        first_q <= 1'b0;
      end
      if (cmd_i.sweep_clr) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + ADDR_W'(1);
      end
      if (cmd_i.cap_in) begin
        err_q <= 1'b0;
      end else if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.kind       = kind_q;
  assign status_o.ins_ok     = (pos_q != '0)
                             && ((LEN_W + 1)'(pos_q) <= (LEN_W + 1)'(count_q) + (LEN_W + 1)'(1))
                             && (count_q < LEN_W'(CAPACITY));
  assign status_o.del_ok     = (pos_q != '0) && (LEN_W'(pos_q) <= count_q);
  assign status_o.slot_bad   = (rd_q == FREE_SLOT) || (rd_q == HEAD_SLOT);
  assign status_o.walk_done  = (remain_q == '0);
  assign status_o.sweep_last = (sweep_q == HEAD_SLOT);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_length_o = out_length_q;

  // The element count never passes the number of slots that can hold data.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= LEN_W'(CAPACITY))
    else $error("element count above capacity");

  // A chain walk never steps past the requested position.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.walk_step |-> remain_q != '0)
    else $error("walk stepped with no steps left");

  // A new result is loaded only when the previous one has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // An insert that completes grows the list by exactly one element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> count_q == $past(count_q) + LEN_W'(1))
    else $error("count did not advance on insert");

endmodule

// ===== hw/rtl/static_linked_list_engine.sv =====
// Channel | Dir | Beat contents             | Handshake
// req_i   | in  | kind, position, value     | valid / ready
// rsp_o   | out | status, length            | valid / ready
//
// One request beat is taken at a time; the next one is taken while the last result waits.
// Insert and delete each walk along the chain to the requested position,
// one link memory read per cycle; rejected requests and unused kinds finish with an error status.
// Clear rewrites every link.
// After reset the link memory is rebuilt before the first request beat is taken.
// A stalled result holds in the output register and blocks only the finish of the next item.
module static_linked_list_engine import slle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  slle_req_if.sink   req_i,
  slle_rsp_if.source rsp_o
);

  slle_cmd_t    cmd;
  slle_status_t status;

  slle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slle_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .kind_i       (req_i.kind),
    .position_i   (req_i.position),
    .value_i      (req_i.value),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (rsp_o.status),
    .out_length_o (rsp_o.length)
  );

endmodule
